// ----- design/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the CSV stream tokenizer
// Character codes, field count limit, parse modes and the entry format of
// the queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] MAX_FIELDS = 8'd255;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] SEP_RESET = 8'd44;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_QUOTED  = 2'd1,
    MODE_PENDING = 2'd2
  } parse_mode_t;

  // byte class flags, set by the front
  typedef struct packed {
    logic eos;
    logic is_lf;
    logic is_sep;
    logic is_quote;
  } tok_cls_t;

  typedef struct packed {
    logic [7:0] data;
    tok_cls_t   cls;
  } tok_entry_t;

endpackage

// ----- design/cst_front.sv -----
// ----------------------------------------------------------------------------
// cst_front: request intake and classification
// Holds the separator register, classifies each accepted byte and pushes it
// into a two-entry queue that the back drains.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_stream,
  output logic                q_valid,
  output cst_pkg::tok_entry_t q_entry,
  input  logic                q_pop
);

  logic [7:0]          sep_r;
  cst_pkg::tok_entry_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  logic                push;
  cst_pkg::tok_entry_t entry;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    entry.data         = in_byte;
    entry.cls.eos      = in_end_of_stream;
    entry.cls.is_lf    = (in_byte == cst_pkg::CH_LF);
    entry.cls.is_sep   = (in_byte == sep_r);
    entry.cls.is_quote = (in_byte == cst_pkg::CH_QUOTE);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= cst_pkg::SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ----- design/cst_back.sv -----
// ----------------------------------------------------------------------------
// cst_back: tokenizer state machine and result register
// Pops classified bytes, updates parse mode and field/row counters, and
// loads one result into the output register when the byte produces one.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cst_pkg::tok_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_field_end,
  output logic                out_row_end,
  output logic                out_format_error,
  output logic [7:0]          out_expected_count,
  output logic [7:0]          out_got_count,
  output logic [31:0]         out_error_row
);

  cst_pkg::parse_mode_t    mode_r, mode_nxt;
  logic [cst_pkg::CNT_W-1:0] fields_r, fields_nxt;
  logic [cst_pkg::CNT_W-1:0] width_r, width_nxt;
  logic [cst_pkg::CNT_W-1:0] cnt_inc;
  logic                    has_data_r, has_data_nxt;
  logic [31:0]             row_r, row_nxt;
  logic                    err_r, err_nxt;
  logic                    out_valid_r;

  logic                    take;
  logic                    plain;
  logic                    do_emit;
  logic                    do_field;
  logic                    do_row;
  logic                    res;
  logic                    res_bv, res_fe, res_re, res_fmt;
  logic [7:0]              res_byte, res_exp, res_got;
  logic [31:0]             res_row;

  assign take      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign cnt_inc   = (fields_r == cst_pkg::MAX_FIELDS) ? cst_pkg::MAX_FIELDS
                                                       : fields_r + 1'b1;

  always_comb begin
    mode_nxt     = mode_r;
    fields_nxt   = fields_r;
    width_nxt    = width_r;
    has_data_nxt = has_data_r;
    row_nxt      = row_r;
    err_nxt      = err_r;
    plain        = 1'b0;
    do_emit      = 1'b0;
    do_field     = 1'b0;
    do_row       = 1'b0;
    res_bv       = 1'b0;
    res_fe       = 1'b0;
    res_re       = 1'b0;
    res_fmt      = 1'b0;
    res_byte     = 8'd0;
    res_exp      = 8'd0;
    res_got      = 8'd0;
    res_row      = 32'd0;

    // drop everything once the format error is latched
    if (take && !err_r) begin
      if (q_entry.cls.eos) begin
        mode_nxt = cst_pkg::MODE_PLAIN;
        do_row   = (fields_r != '0) || has_data_r;
      end else begin
        case (mode_r)
          cst_pkg::MODE_QUOTED: begin
            if (q_entry.cls.is_quote) begin
              mode_nxt = cst_pkg::MODE_PENDING;
            end else begin
              do_emit = 1'b1;
            end
          end
          cst_pkg::MODE_PENDING: begin
            // doubled quote is a literal quote
            if (q_entry.cls.is_quote) begin
              mode_nxt = cst_pkg::MODE_QUOTED;
              do_emit  = 1'b1;
            end else begin
              mode_nxt = cst_pkg::MODE_PLAIN;
              plain    = 1'b1;
            end
          end
          default: begin
            mode_nxt = cst_pkg::MODE_PLAIN;
            plain    = 1'b1;
          end
        endcase
        if (plain) begin
          if (q_entry.cls.is_lf) begin
            do_row = 1'b1;
          end else if (q_entry.cls.is_sep) begin
            do_field = 1'b1;
          end else if (q_entry.cls.is_quote) begin
            mode_nxt     = cst_pkg::MODE_QUOTED;
            has_data_nxt = 1'b1;
          end else begin
            do_emit = 1'b1;
          end
        end
      end

      if (do_emit) begin
        has_data_nxt = 1'b1;
        res_bv       = 1'b1;
        res_byte     = q_entry.data;
      end
      if (do_field) begin
        fields_nxt   = cnt_inc;
        has_data_nxt = 1'b0;
        res_fe       = 1'b1;
      end
      if (do_row) begin
        has_data_nxt = 1'b0;
        res_fe       = 1'b1;
        if ((width_r != '0) && (width_r != cnt_inc)) begin
          err_nxt    = 1'b1;
          fields_nxt = cnt_inc;
          res_fmt    = 1'b1;
          res_exp    = width_r[7:0];
          res_got    = cnt_inc[7:0];
          res_row    = row_r;
        end else begin
          if (width_r == '0) begin
            width_nxt = cnt_inc;
          end
          res_re     = 1'b1;
          fields_nxt = '0;
          row_nxt    = row_r + 32'd1;
        end
      end
    end
    res = do_emit || do_field || do_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cst_pkg::MODE_PLAIN;
      fields_r    <= '0;
      width_r     <= '0;
      has_data_r  <= 1'b0;
      row_r       <= 32'd1;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      fields_r   <= fields_nxt;
      width_r    <= width_nxt;
      has_data_r <= has_data_nxt;
      row_r      <= row_nxt;
      err_r      <= err_nxt;
      if (take && res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res) begin
      out_byte           <= res_byte;
      out_byte_valid     <= res_bv;
      out_field_end      <= res_fe;
      out_row_end        <= res_re;
      out_format_error   <= res_fmt;
      out_expected_count <= res_exp;
      out_got_count      <= res_got;
      out_error_row      <= res_row;
    end
  end

endmodule

// ----- design/csv_stream_tokenizer.sv -----
// ----------------------------------------------------------------------------
// csv_stream_tokenizer: CSV byte stream to field/row tokens
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_byte, in_end_of_stream
// out_      output     out_valid/out_stall content byte, field/row ends, error
// cfg_      input      cfg_wr_en          cfg_wr_data (separator byte)
//
// One byte per cycle sustained while out_stall is low, bounded by the back's
// per-byte mode update. An accepted request is written into the queue, then
// popped into the result register that drives the outputs.
// Bytes that give no result (opening quote, errors latched) still take a slot.
// Reset is synchronous, active low; separator resets to a comma.
// Output stall backs up through the two-entry queue to in_stall.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_field_end,
  output logic        out_row_end,
  output logic        out_format_error,
  output logic [7:0]  out_expected_count,
  output logic [7:0]  out_got_count,
  output logic [31:0] out_error_row
);

  logic                q_valid;
  logic                q_pop;
  cst_pkg::tok_entry_t q_entry;

  cst_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop)
  );

  cst_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (q_entry),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_field_end      (out_field_end),
    .out_row_end        (out_row_end),
    .out_format_error   (out_format_error),
    .out_expected_count (out_expected_count),
    .out_got_count      (out_got_count),
    .out_error_row      (out_error_row)
  );

endmodule
